FILE: hdl/kmlm_pkg.sv
// Shared types and constants for the keyed multiset list manager.
`default_nettype none

package kmlm_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_RETRIEVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADKEY   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [7:0] KEY_MAX    = 8'd3;
  localparam int         NUM_CHAINS = 4;
  localparam int         KEY_BITS   = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  key;
    logic [15:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic        last;
    logic [6:0]  item_total;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch_in;
    logic       rd_free;
    logic       rd_head;
    logic       ins_write;
    logic       ins_link;
    logic       del_rd;
    logic       del_wr;
    logic       ret_start;
    logic       ret_rd;
    logic       ret_step;
    logic       out_load;
    logic       out_pay;
    logic [1:0] out_status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd_code;
    logic       key_ok;
    logic       head_null;
    logic       pool_full;
    logic       next_null;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/kmlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kmlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kmlm_datapath.sv
// Datapath: chain heads, free list, entry counters, link and payload RAMs, result register.
`default_nettype none

module kmlm_datapath import kmlm_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_item,
  input  wire ctrl_cmd_t cmd,
  output dp_stat_t       st,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

  in_item_t      in_q;
  logic [PW-1:0] chain_head [NUM_CHAINS];
  logic [PW-1:0] free_head;   // recycled entries only
  logic [PW-1:0] fresh;       // entries never yet handed out start here
  logic [PW-1:0] count;
  logic [PW-1:0] e_ptr;
  logic [PW-1:0] free_next;
  logic [PW-1:0] node;

  logic [KEY_BITS-1:0] key_idx;
  logic [PW-1:0]       head;
  logic                head_null;
  logic                free_empty;

  logic          link_we, link_re;
  logic [AW-1:0] link_waddr, link_raddr;
  logic [PW-1:0] link_wdata, link_rdata;
  logic [15:0]   pay_rdata;

  logic [PW+6:0] cnt_ext;

  assign key_idx    = in_q.key[KEY_BITS-1:0];
  assign head       = chain_head[key_idx];
  assign head_null  = (head == NIL);
  assign free_empty = (free_head == NIL);
  assign cnt_ext    = {7'd0, count};

  always_comb begin
    link_re = (cmd.rd_free & ~free_empty) | (cmd.rd_head & ~head_null)
            | cmd.del_rd | cmd.ret_rd;
    priority if (cmd.rd_free) begin
      link_raddr = free_head[AW-1:0];
    end else if (cmd.ret_rd) begin
      link_raddr = node[AW-1:0];
    end else begin
      link_raddr = head[AW-1:0];
    end

    link_we = cmd.ins_write | cmd.ins_link | cmd.del_wr;
    priority if (cmd.ins_write) begin
      link_waddr = e_ptr[AW-1:0];
      link_wdata = head_null ? NIL : link_rdata;
    end else if (cmd.ins_link) begin
      link_waddr = head[AW-1:0];
      link_wdata = e_ptr;
    end else begin
      link_waddr = head[AW-1:0];
      link_wdata = free_head;
    end
  end

  kmlm_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  kmlm_ram #(.WIDTH(16), .DEPTH(POOL_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (e_ptr[AW-1:0]),
    .wdata (in_q.handle),
    .re    (cmd.ret_rd),
    .raddr (node[AW-1:0]),
    .rdata (pay_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHAINS; i++) begin
        chain_head[i] <= NIL;
      end
      free_head <= NIL;
      fresh     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_write) begin
        if (head_null) begin
          chain_head[key_idx] <= e_ptr;
        end
        if (!free_empty) begin
          free_head <= free_next;
        end else begin
          fresh <= fresh + 1'b1;
        end
        count <= count + 1'b1;
      end
      if (cmd.del_wr) begin
        chain_head[key_idx] <= link_rdata;
        free_head           <= head;
        if (count != '0) begin
          count <= count - 1'b1;
        end
      end
      out_valid <= cmd.out_load | (out_valid & out_stall);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_q <= in_item;
    end
    if (cmd.rd_free) begin
      e_ptr <= free_empty ? fresh : free_head;
    end
    if (cmd.rd_head) begin
      free_next <= link_rdata;
    end
    if (cmd.ret_start) begin
      node <= head;
    end else if (cmd.ret_step) begin
      node <= link_rdata;
    end
    if (cmd.out_load) begin
      out_item.status     <= cmd.out_status;
      out_item.handle_out <= cmd.out_pay ? pay_rdata : 16'd0;
      out_item.last       <= cmd.out_pay ? (link_rdata == NIL) : 1'b1;
      out_item.item_total <= cnt_ext[6:0];
    end
  end

  assign st.cmd_code  = in_q.cmd;
  assign st.key_ok    = (in_q.key <= KEY_MAX);
  assign st.head_null = head_null;
  assign st.pool_full = free_empty & (fresh == NIL);
  assign st.next_null = (link_rdata == NIL);
  assign st.out_free  = ~out_valid | ~out_stall;

endmodule

`default_nettype wire

FILE: hdl/kmlm_ctrl.sv
// Controller: sequences each command through the datapath.
`default_nettype none

module kmlm_ctrl import kmlm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t st,
  output ctrl_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_FREE, S_INS_HEAD, S_INS_WRITE, S_INS_LINK,
    S_DEL_RD, S_DEL_WR, S_RET_RD, S_RET_EMIT, S_FINISH
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_status, res_status_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    res_status_next = res_status;
    unique case (state)
      S_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_next = ST_OK;
        unique case (st.cmd_code)
          CMD_INSERT: begin
            priority if (!st.key_ok) begin
              res_status_next = ST_BADKEY;
              state_next      = S_FINISH;
            end else if (st.pool_full) begin
              res_status_next = ST_FULL;
              state_next      = S_FINISH;
            end else begin
              state_next = S_INS_FREE;
            end
          end
          CMD_DELETE: begin
            if (!st.key_ok || st.head_null) begin
              res_status_next = ST_NOTFOUND;
              state_next      = S_FINISH;
            end else begin
              state_next = S_DEL_RD;
            end
          end
          CMD_RETRIEVE: begin
            if (!st.key_ok || st.head_null) begin
              res_status_next = ST_NOTFOUND;
              state_next      = S_FINISH;
            end else begin
              cmd.ret_start = 1'b1;
              state_next    = S_RET_RD;
            end
          end
          default: begin
            res_status_next = ST_BADKEY;
            state_next      = S_FINISH;
          end
        endcase
      end
      S_INS_FREE: begin
        cmd.rd_free = 1'b1;
        state_next  = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_INS_WRITE;
      end
      S_INS_WRITE: begin
        cmd.ins_write = 1'b1;
        state_next    = st.head_null ? S_FINISH : S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        state_next   = S_FINISH;
      end
      S_DEL_RD: begin
        cmd.del_rd = 1'b1;
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.del_wr = 1'b1;
        state_next = S_FINISH;
      end
      S_RET_RD: begin
        cmd.ret_rd = 1'b1;
        state_next = S_RET_EMIT;
      end
      S_RET_EMIT: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_pay    = 1'b1;
          cmd.out_status = ST_OK;
          cmd.ret_step   = 1'b1;
          state_next     = st.next_null ? S_IDLE : S_RET_RD;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/keyed_multiset_list_manager.sv
// Top level of the keyed multiset list manager: four handle chains over a shared entry pool.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+---------------------------------------
//   in      | in        | in_valid/in_stall   | in_item  {cmd, key, handle}
//   out     | out       | out_valid/out_stall | out_item {status, handle_out, last,
//           |           |                     |           item_total}
//
// Sequence: one command at a time; a RAM step is one registered link read or one write.
//   Insert reads the free list and the chain head, writes the entry and, if the chain has
//   a head, links it in; delete reads then writes; retrieve reads and emits each handle.
// Reset: synchronous; no clearing pass, unused entries come from a fresh-entry counter
//   once the recycled free list is empty.
// Stalls: a result waits in the output register; the controller holds in its emit or
//   finish step until the register is free, and takes a new beat only when idle.
`default_nettype none

module keyed_multiset_list_manager import kmlm_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  // sequencer: walks each command through its RAM steps
  kmlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // chain heads, free list, RAMs and the result register
  kmlm_datapath #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded while output register busy");

  // any failing status closes the reply and carries no handle
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != ST_OK) |-> (out_item.last && out_item.handle_out == 16'd0))
    else $error("error result not a single, empty beat");

  // a new beat is taken only while nothing is being written to the link RAM
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !(cmd.ins_write || cmd.ins_link || cmd.del_wr))
    else $error("input accepted during a list update");

endmodule

`default_nettype wire

FILE: sim/kmlm_checker.sv
// Checker for the keyed multiset list manager: tracks the chains and scores every result beat.
`default_nettype none

module kmlm_checker import kmlm_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_item,
  output int             mismatches,
  output int             outstanding
);

  localparam int         AW       = $clog2(POOL_DEPTH);
  localparam logic [6:0] NO_ENTRY = 7'(POOL_DEPTH);

  // shadow of the chains and the pool
  logic [6:0]  chain_first [NUM_CHAINS];
  logic [6:0]  next_link   [POOL_DEPTH];
  logic [15:0] handle_store[POOL_DEPTH];
  logic [6:0]  free_entry;
  logic [6:0]  entry_count;

  out_item_t   replies_due[$];
  int          fault_total = 0;

  task automatic clear_pool();
    for (int c = 0; c < NUM_CHAINS; c++) chain_first[c] = NO_ENTRY;
    for (int e = 0; e < POOL_DEPTH; e++) begin
      next_link[e]    = 7'(e + 1);
      handle_store[e] = '0;
    end
    free_entry  = '0;
    entry_count = '0;
    replies_due.delete();
  endtask

  function automatic out_item_t reply(logic [1:0] st, logic [15:0] h, logic lst);
    out_item_t r;
    r.status     = st;
    r.handle_out = h;
    r.last       = lst;
    r.item_total = entry_count;
    return r;
  endfunction

  // append one predicted beat at the tail
  task automatic add_reply(input out_item_t r);
    replies_due.insert(replies_due.size(), r);
  endtask

  // work out the result beats one command beat causes
  task automatic apply_command(input in_item_t beat);
    logic [6:0] e;
    logic [6:0] head;
    logic [6:0] node;
    logic [6:0] nxt;
    logic [1:0] k;
    int         n;
    k = beat.key[1:0];
    case (beat.cmd)
      CMD_INSERT: begin
        if (beat.key > KEY_MAX) begin
          add_reply(reply(ST_BADKEY, '0, 1'b1));
        end else if (free_entry == NO_ENTRY) begin
          add_reply(reply(ST_FULL, '0, 1'b1));
        end else begin
          e = free_entry;
          free_entry = next_link[e[AW-1:0]];
          handle_store[e[AW-1:0]] = beat.handle;
          head = chain_first[k];
          if (head == NO_ENTRY) begin
            next_link[e[AW-1:0]] = NO_ENTRY;
            chain_first[k]       = e;
          end else begin
            // goes in just behind the head
            next_link[e[AW-1:0]]    = next_link[head[AW-1:0]];
            next_link[head[AW-1:0]] = e;
          end
          entry_count++;
          add_reply(reply(ST_OK, '0, 1'b1));
        end
      end
      CMD_DELETE: begin
        if (beat.key > KEY_MAX || chain_first[k] == NO_ENTRY) begin
          add_reply(reply(ST_NOTFOUND, '0, 1'b1));
        end else begin
          e = chain_first[k];
          chain_first[k]       = next_link[e[AW-1:0]];
          next_link[e[AW-1:0]] = free_entry;
          free_entry           = e;
          if (entry_count != 0) entry_count--;
          add_reply(reply(ST_OK, '0, 1'b1));
        end
      end
      CMD_RETRIEVE: begin
        if (beat.key > KEY_MAX || chain_first[k] == NO_ENTRY) begin
          add_reply(reply(ST_NOTFOUND, '0, 1'b1));
        end else begin
          node = chain_first[k];
          n    = 0;
          while (node != NO_ENTRY && n < POOL_DEPTH) begin
            nxt = next_link[node[AW-1:0]];
            add_reply(reply(ST_OK, handle_store[node[AW-1:0]],
                            nxt == NO_ENTRY || n + 1 >= POOL_DEPTH));
            n++;
            node = nxt;
          end
        end
      end
      default: add_reply(reply(ST_BADKEY, '0, 1'b1));
    endcase
  endtask

  task automatic log_fault(input string what, input out_item_t want);
    fault_total++;
    if (fault_total <= 10)
      $display("%0t: %s: want st=%0d h=%h last=%b total=%0d, got st=%0d h=%h last=%b total=%0d",
               $time, what, want.status, want.handle_out, want.last, want.item_total,
               out_item.status, out_item.handle_out, out_item.last, out_item.item_total);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_pool();
    end else begin
      if (in_valid && !in_stall) apply_command(in_item);
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          log_fault("unexpected beat", '0);
        end else if (out_item.status     !== replies_due[0].status     ||
                     out_item.handle_out !== replies_due[0].handle_out ||
                     out_item.last       !== replies_due[0].last       ||
                     out_item.item_total !== replies_due[0].item_total) begin
          log_fault("mismatch", replies_due.pop_front());
        end else begin
          void'(replies_due.pop_front());
        end
      end
    end
    outstanding <= replies_due.size();
    mismatches  <= fault_total;
  end

endmodule

`default_nettype wire

FILE: sim/tb_keyed_multiset_list_manager.sv
// Testbench top for the keyed multiset list manager: stimulus, back-pressure and verdict.
`default_nettype none

module tb_keyed_multiset_list_manager import kmlm_pkg::*; ();

  // command code that names no operation; the block must reject it
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // traffic mixes for the random part
  typedef enum int {MIX_FILL, MIX_BLEND, MIX_DRAIN, MIX_NOISE} mix_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        mismatches;
  int        outstanding;
  int        beats_sent = 0;

  always #6 clk = ~clk;

  keyed_multiset_list_manager #(.POOL_DEPTH(64)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  kmlm_checker #(.POOL_DEPTH(64)) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic in_item_t command(logic [1:0] c, logic [7:0] k, logic [15:0] h);
    in_item_t it;
    it.cmd    = c;
    it.key    = k;
    it.handle = h;
    return it;
  endfunction

  // Offer one beat and hold it until taken. Valid only drops when there is a gap,
  // so back-to-back beats never see valid lowered and raised in one step.
  // Every third stretch of 30 beats goes out with no gaps at all.
  task automatic offer_beat(input in_item_t it);
    int gap;
    gap = ((beats_sent / 30) % 3 == 2) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // random command shaped by the current traffic mix
  function automatic in_item_t random_command(mix_t mix, logic [7:0] fav_key);
    int         roll;
    logic [1:0] c;
    logic [7:0] k;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  c = (roll < 85) ? CMD_INSERT : CMD_RETRIEVE;
      MIX_DRAIN: c = (roll < 65) ? CMD_DELETE : (roll < 80) ? CMD_INSERT : CMD_RETRIEVE;
      MIX_BLEND: c = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_DELETE : CMD_RETRIEVE;
      default:   c = 2'($urandom_range(0, 3));
    endcase
    roll = $urandom_range(0, 99);
    // mostly good keys (half bad in the noise mix), leaning on one chain so that it grows long
    if (roll < ((mix == MIX_NOISE) ? 50 : 8)) k = 8'($urandom_range(4, 255));
    else if (roll < 55)                       k = fav_key;
    else                                      k = 8'($urandom_range(0, 3));
    return command(c, k, 16'($urandom_range(0, 65535)));
  endfunction

  // Receiver: a random stall before each result beat, a quiet stretch every third block
  // of 40 beats, and one long hold-off once traffic is flowing so the output register
  // fills and the block stops taking command beats.
  initial begin
    int  hold;
    int  taken;
    bit  held_off;
    taken    = 0;
    held_off = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held_off && taken >= 120) begin
        held_off = 1'b1;
        hold     = 400;
      end else if ((taken / 40) % 3 == 1) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    mix_t       plan_mix[6];
    int         plan_len[6];
    logic [7:0] fav_key;
    plan_mix = '{MIX_FILL, MIX_BLEND, MIX_DRAIN, MIX_NOISE, MIX_FILL, MIX_DRAIN};
    plan_len = '{90, 50, 90, 30, 40, 30};
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty chains, insert ordering, rejects and extremes
    offer_beat(command(CMD_RETRIEVE, 8'd0,   16'h0000));  // empty chain
    offer_beat(command(CMD_DELETE,   8'd0,   16'hFFFF));  // delete on empty chain
    offer_beat(command(CMD_INSERT,   8'd0,   16'h0000));  // becomes head
    offer_beat(command(CMD_INSERT,   8'd0,   16'hFFFF));  // behind head
    offer_beat(command(CMD_INSERT,   8'd0,   16'h1234));  // behind head, before FFFF
    offer_beat(command(CMD_RETRIEVE, 8'd0,   16'hFFFF));  // 0000, 1234, FFFF
    offer_beat(command(CMD_INSERT,   8'd1,   16'hA5A5));
    offer_beat(command(CMD_INSERT,   8'd2,   16'h5A5A));
    offer_beat(command(CMD_INSERT,   8'd3,   16'h0001));
    offer_beat(command(CMD_INSERT,   8'd4,   16'h8000));  // bad key, just above range
    offer_beat(command(CMD_INSERT,   8'hFF,  16'h7FFF));  // bad key, top
    offer_beat(command(CMD_INSERT,   8'h80,  16'h00FF));
    offer_beat(command(CMD_DELETE,   8'hFF,  16'h0000));  // never stored: not found
    offer_beat(command(CMD_RETRIEVE, 8'd4,   16'h0000));  // never stored: not found
    offer_beat(command(CMD_SPARE,    8'd0,   16'h0000));  // no such operation
    offer_beat(command(CMD_SPARE,    8'hFF,  16'hFFFF));
    offer_beat(command(CMD_DELETE,   8'd0,   16'hABCD));  // handle ignored, head goes
    offer_beat(command(CMD_RETRIEVE, 8'd0,   16'h0000));  // 1234, FFFF
    offer_beat(command(CMD_RETRIEVE, 8'd3,   16'h0000));
    offer_beat(command(CMD_DELETE,   8'd1,   16'h0000));
    offer_beat(command(CMD_RETRIEVE, 8'd1,   16'h0000));  // emptied chain
    offer_beat(command(CMD_DELETE,   8'd1,   16'h0000));
    offer_beat(command(CMD_RETRIEVE, 8'd2,   16'h0000));

    // random: fill to a full pool, churn, drain, noise, then again
    for (int p = 0; p < 6; p++) begin
      fav_key = 8'($urandom_range(0, 3));
      for (int i = 0; i < plan_len[p]; i++)
        offer_beat(random_command(plan_mix[p], fav_key));
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_keyed_multiset_list_manager OK");
    end else begin
      $display("tb_keyed_multiset_list_manager NOT OK");
    end
    $finish;
  end

  // watchdog: well beyond the slowest legal run
  initial begin
    #(12 * 600000);
    $display("tb_keyed_multiset_list_manager NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hdl/kmlm_pkg.sv
hdl/kmlm_ram.sv
hdl/kmlm_datapath.sv
hdl/kmlm_ctrl.sv
hdl/keyed_multiset_list_manager.sv
sim/kmlm_checker.sv
sim/tb_keyed_multiset_list_manager.sv
